@@ src/bsa_pkg.sv @@
`default_nettype none
package bsa_pkg;

	localparam int SLOTS = 64;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int GRP_SIZE = 8;
	localparam int GRP_W = $clog2(GRP_SIZE);
	localparam int GROUPS = SLOTS / GRP_SIZE;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE = 1'b1;

	localparam logic MODE_NEXT_FIT = 1'b0;
	localparam logic MODE_FIRST_FIT = 1'b1;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_FULL = 2'd1,
		ST_NOT_USED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic search;
		logic commit;
	} dp_cmd_t;

endpackage
`default_nettype wire

@@ src/bsa_ctrl.sv @@
`default_nettype none
module bsa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output bsa_pkg::dp_cmd_t  cmd
);
	import bsa_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   commit_ok;

	// the output register is free, or its word leaves this cycle
	assign commit_ok = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_SEARCH;
			end
			S_SEARCH: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (commit_ok) state_d = in_valid ? S_SEARCH : S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			S_SEARCH: begin
				cmd.search = 1'b1;
			end
			S_DONE: begin
				cmd.commit = commit_ok;
				in_stall = !commit_ok;
				cmd.load = commit_ok && in_valid;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

@@ src/bsa_datapath.sv @@
`default_nettype none
module bsa_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bsa_pkg::dp_cmd_t           cmd,
	input  logic                       cfg_we,
	input  logic                       cfg_data,
	input  logic                       req_type,
	input  logic [bsa_pkg::SLOT_W-1:0] free_index,
	output logic [bsa_pkg::SLOT_W-1:0] slot_index,
	output logic [1:0]                 status
);
	import bsa_pkg::*;

	logic [SLOTS-1:0]  used_q;
	logic [SLOT_W-1:0] next_q;
	logic              mode_q;
	logic              req_q;
	logic [SLOT_W-1:0] idx_q;
	logic [SLOT_W-1:0] slot_q;
	status_t           status_q;

	logic [SLOT_W-1:0] start;
	logic [SLOTS-1:0]  mask_a;
	logic [SLOTS-1:0]  mask_b;

	logic [GROUPS-1:0] hit_a_s1;
	logic [GROUPS-1:0] hit_b_s1;
	logic [GRP_W-1:0]  off_a_s1 [GROUPS];
	logic [GRP_W-1:0]  off_b_s1 [GROUPS];

	logic              found_a;
	logic              found_b;
	logic [SLOT_W-1:0] sel_a;
	logic [SLOT_W-1:0] sel_b;
	logic              found;
	logic [SLOT_W-1:0] grant;
	logic [SLOT_W-1:0] grant_inc;

	function automatic logic [GRP_W:0] enc_group(logic [GRP_SIZE-1:0] v);
		logic [GRP_W:0] r;
		r = '0;
		for (int i = GRP_SIZE - 1; i >= 0; i--) begin
			if (v[i]) r = {1'b1, GRP_W'(i)};
		end
		return r;
	endfunction

	// next-fit restarts at slot 1 when the pointer sits on slot 0
	assign start = (next_q == '0) ? SLOT_W'(1) : next_q;

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			if (mode_q == MODE_FIRST_FIT) begin
				mask_a[i] = !used_q[i];
				mask_b[i] = 1'b0;
			end else begin
				mask_a[i] = !used_q[i] && (SLOT_W'(i) >= start);
				mask_b[i] = !used_q[i] && (i != 0);
			end
		end
	end

	// first level: lowest free bit inside each group, registered
	always_ff @(posedge clk) begin
		if (cmd.search) begin
			for (int g = 0; g < GROUPS; g++) begin
				{hit_a_s1[g], off_a_s1[g]} <= enc_group(mask_a[g*GRP_SIZE +: GRP_SIZE]);
				{hit_b_s1[g], off_b_s1[g]} <= enc_group(mask_b[g*GRP_SIZE +: GRP_SIZE]);
			end
		end
	end

	// second level: lowest group with a hit; the wrapped range only if the first misses
	always_comb begin
		found_a = 1'b0;
		found_b = 1'b0;
		sel_a = '0;
		sel_b = '0;
		for (int g = GROUPS - 1; g >= 0; g--) begin
			if (hit_a_s1[g]) begin
				found_a = 1'b1;
				sel_a = SLOT_W'({g[SLOT_W-1:0], off_a_s1[g]});
			end
			if (hit_b_s1[g]) begin
				found_b = 1'b1;
				sel_b = SLOT_W'({g[SLOT_W-1:0], off_b_s1[g]});
			end
		end
		found = found_a || found_b;
		grant = found_a ? sel_a : (found_b ? sel_b : '0);
		grant_inc = (grant == SLOT_W'(SLOTS - 1)) ? SLOT_W'(1) : grant + SLOT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			next_q <= SLOT_W'(1);
			mode_q <= MODE_NEXT_FIT;
		end else begin
			if (cfg_we) mode_q <= cfg_data;
			if (cmd.commit) begin
				if (req_q == REQ_FREE) begin
					used_q[idx_q] <= 1'b0;
				end else if (found) begin
					used_q[grant] <= 1'b1;
					if (mode_q == MODE_NEXT_FIT) next_q <= grant_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			idx_q <= free_index;
		end
		if (cmd.commit) begin
			if (req_q == REQ_FREE) begin
				slot_q <= idx_q;
				status_q <= used_q[idx_q] ? ST_OK : ST_NOT_USED;
			end else begin
				slot_q <= grant;
				status_q <= found ? ST_OK : ST_FULL;
			end
		end
	end

	assign slot_index = slot_q;
	assign status = status_q;

endmodule
`default_nettype wire

@@ src/bitmap_slot_allocator_unit.sv @@
`default_nettype none
// Bitmap slot allocator: one used bit per slot, 64 slots.
// Input channel (in_valid / in_stall): req_type 0 allocates a slot, 1 frees
// free_index. Output channel (out_valid / out_stall): one word per request,
// slot_index is the granted slot (0 when full) or the echoed freed slot;
// status is 0 ok, 1 no free slot, 2 freed slot was not in use.
// cfg_we / cfg_data write alloc_mode: 0 next-fit from a rotating pointer that
// never grants slot 0, 1 first-fit lowest free slot. Write only while idle.
// The search is a two-level priority encoder; the group level is registered in
// the search state, the group pick, map update and output register load happen
// in the done state, which waits while a stalled receiver holds the output.
// One request is in flight at a time; the next is taken on the cycle its
// predecessor commits to the output register.
// While the receiver stalls, the output word holds; a finished request waits
// in the datapath and in_stall stays high until the output register frees up.
// Reset clears the whole map at once, sets the next-fit pointer to slot 1 and
// the mode to next-fit; the block takes requests as soon as reset is released.
module bitmap_slot_allocator_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       req_type,
	input  logic [bsa_pkg::SLOT_W-1:0] free_index,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [bsa_pkg::SLOT_W-1:0] slot_index,
	output logic [1:0]                 status
);
	import bsa_pkg::*;

	dp_cmd_t cmd;

	bsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	bsa_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.req_type   (req_type),
		.free_index (free_index),
		.slot_index (slot_index),
		.status     (status)
	);

	// one request in flight: the cycle after a request is taken never takes another
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request taken during search");

	a_full_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_FULL) |-> (slot_index == '0))
		else $error("full status with nonzero slot");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK || status == ST_FULL || status == ST_NOT_USED))
		else $error("undefined status code");

	// a new output word always follows a search cycle, where the input is stalled
	a_word_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(out_valid)) |-> $past(in_stall, 2))
		else $error("output word without a search cycle");

endmodule
`default_nettype wire

@@ sim/bitmap_slot_allocator_unit_tb.sv @@
`timescale 1ns / 100ps
module bitmap_slot_allocator_unit_tb;
	import bsa_pkg::*;

	typedef struct {
		logic              req;
		logic [SLOT_W-1:0] idx;
	} request_t;

	typedef struct {
		logic              req;
		logic [SLOT_W-1:0] slot;
		status_t           st;
	} grant_t;

	typedef struct {
		logic [SLOTS-1:0]  used;
		logic [SLOT_W-1:0] ptr;
		logic              mode;
	} alloc_model_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic              cfg_data = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              req_type = REQ_ALLOC;
	logic [SLOT_W-1:0] free_index = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [SLOT_W-1:0] slot_index;
	logic [1:0]        status;

	request_t     req_q[$];
	grant_t       grant_q[$];
	alloc_model_t pred_model;
	alloc_model_t plan_model;
	logic         in_fire = 1'b0;
	logic         calm = 1'b0;
	int           errors = 0;
	int           planned = 0;
	int           n_alloc = 0;
	int           n_free = 0;
	int           n_full = 0;
	int           n_warn = 0;

	bitmap_slot_allocator_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.free_index(free_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.slot_index(slot_index),
		.status(status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void apply_request(inout alloc_model_t m, input logic req,
			input logic [SLOT_W-1:0] idx, output logic [SLOT_W-1:0] slot,
			output status_t st);
		int start;
		int s;
		int found_at;
		slot = '0;
		found_at = -1;
		st = ST_OK;
		if (req == REQ_FREE) begin
			if (int'(idx) < SLOTS) begin
				st = m.used[idx] ? ST_OK : ST_NOT_USED;
				m.used[idx] = 1'b0;
			end else begin
				st = ST_NOT_USED;
			end
			slot = idx;
		end else begin
			if (m.mode == MODE_FIRST_FIT) begin
				for (s = 0; s < SLOTS; s++)
					if (!m.used[s] && found_at < 0) found_at = s;
			end else begin
				start = int'(m.ptr);
				if (start == 0 || start >= SLOTS) start = 1;
				for (s = start; s < SLOTS; s++)
					if (!m.used[s] && found_at < 0) found_at = s;
				// wrap, skipping slot zero
				for (s = 1; s < start; s++)
					if (!m.used[s] && found_at < 0) found_at = s;
			end
			if (found_at >= 0) begin
				m.used[found_at] = 1'b1;
				slot = SLOT_W'(found_at);
				st = ST_OK;
				if (m.mode == MODE_NEXT_FIT)
					m.ptr = (found_at + 1 >= SLOTS) ? SLOT_W'(1) : SLOT_W'(found_at + 1);
			end else begin
				st = ST_FULL;
			end
		end
	endfunction

	task automatic queue_request(input logic req, input logic [SLOT_W-1:0] idx,
			output status_t st);
		logic [SLOT_W-1:0] slot;
		request_t r;
		apply_request(plan_model, req, idx, slot, st);
		r.req = req;
		r.idx = idx;
		req_q.push_back(r);
		planned++;
	endtask

	task automatic queue_free_used();
		status_t st;
		int count;
		int pick;
		int s;
		logic [SLOT_W-1:0] idx;
		count = 0;
		for (s = 0; s < SLOTS; s++)
			if (plan_model.used[s]) count++;
		idx = SLOT_W'($urandom_range(SLOTS - 1));
		if (count > 0) begin
			pick = $urandom_range(count - 1);
			for (s = 0; s < SLOTS; s++) begin
				if (plan_model.used[s]) begin
					if (pick == 0) idx = SLOT_W'(s);
					pick--;
				end
			end
		end
		queue_request(REQ_FREE, idx, st);
	endtask

	task automatic wait_idle();
		while (req_q.size() != 0 || grant_q.size() != 0 || in_valid || in_fire)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_mode(input logic m);
		wait_idle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= m;
		@(negedge clk);
		cfg_we <= 1'b0;
		pred_model.mode = m;
		plan_model.mode = m;
	endtask

	task automatic fill_map();
		status_t st;
		int extra;
		st = ST_OK;
		while (st != ST_FULL) queue_request(REQ_ALLOC, '0, st);
		extra = $urandom_range(2);
		repeat (extra) queue_request(REQ_ALLOC, '0, st);
	endtask

	task automatic drain_map();
		status_t st;
		int n;
		n = $urandom_range(20, 60);
		repeat (n) begin
			if ($urandom_range(99) < 20)
				queue_request(REQ_FREE, SLOT_W'($urandom), st);
			else
				queue_free_used();
		end
	endtask

	task automatic churn_map();
		status_t st;
		int n;
		n = $urandom_range(40, 90);
		repeat (n) begin
			if ($urandom_range(99) < 55)
				queue_request(REQ_ALLOC, SLOT_W'($urandom), st);
			else if ($urandom_range(99) < 85)
				queue_free_used();
			else
				queue_request(REQ_FREE, SLOT_W'($urandom), st);
		end
	endtask

	always @(posedge clk) in_fire <= in_valid && !in_stall;

	// driver: predict on the accepted word, then present the next one
	always @(negedge clk) begin
		request_t r;
		grant_t g;
		if (arst_n) begin
			if (in_fire) begin
				g.req = req_type;
				apply_request(pred_model, req_type, free_index, g.slot, g.st);
				grant_q.push_back(g);
			end
			if (!in_valid || in_fire) begin
				if (req_q.size() != 0 && (calm || $urandom_range(99) >= 35)) begin
					r = req_q.pop_front();
					in_valid <= 1'b1;
					req_type <= r.req;
					free_index <= r.idx;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) out_stall <= !calm && ($urandom_range(99) < 35);
	end

	// monitor: compare each accepted word with the oldest prediction
	always @(posedge clk) begin
		grant_t g;
		if (arst_n && out_valid && !out_stall) begin
			if (grant_q.size() == 0) begin
				$display("%0t: unexpected word slot_index=%0d status=%0d",
					$time, slot_index, status);
				errors++;
			end else begin
				g = grant_q.pop_front();
				if (slot_index !== g.slot) begin
					$display("%0t: slot_index expected %0d actual %0d",
						$time, g.slot, slot_index);
					errors++;
				end
				if (status !== 2'(g.st)) begin
					$display("%0t: status expected %0d actual %0d",
						$time, g.st, status);
					errors++;
				end
				case (g.st)
					ST_FULL:     n_full++;
					ST_NOT_USED: n_warn++;
					default:     ;
				endcase
				if (g.req == REQ_ALLOC) n_alloc++;
			end
		end
	end

	initial begin
		status_t st;
		int phase;
		pred_model.used = '0;
		pred_model.ptr = SLOT_W'(1);
		pred_model.mode = MODE_NEXT_FIT;
		plan_model = pred_model;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// next-fit basics, freeing both used and unused slots
		set_mode(MODE_NEXT_FIT);
		queue_request(REQ_ALLOC, '0, st);
		queue_request(REQ_ALLOC, '0, st);
		queue_request(REQ_FREE, SLOT_W'(2), st);
		queue_request(REQ_FREE, SLOT_W'(2), st);
		queue_request(REQ_FREE, '0, st);
		queue_request(REQ_FREE, '1, st);
		queue_request(REQ_ALLOC, '1, st);
		queue_request(REQ_FREE, SLOT_W'(1), st);
		queue_request(REQ_ALLOC, '0, st);

		// first-fit may grant slot zero
		set_mode(MODE_FIRST_FIT);
		queue_request(REQ_ALLOC, '0, st);
		queue_request(REQ_ALLOC, '0, st);
		queue_request(REQ_FREE, '0, st);
		queue_request(REQ_ALLOC, '0, st);
		queue_request(REQ_FREE, SLOT_W'(6'h2A), st);
		queue_request(REQ_FREE, SLOT_W'(6'h15), st);

		// full map in first-fit, then only slot zero free under next-fit
		fill_map();
		queue_request(REQ_FREE, '0, st);
		set_mode(MODE_NEXT_FIT);
		queue_request(REQ_ALLOC, '0, st);
		queue_request(REQ_ALLOC, '0, st);
		drain_map();

		phase = 0;
		while (planned < 650) begin
			set_mode(logic'($urandom_range(1)));
			calm = (phase == 2);
			case ($urandom_range(3))
				0:       fill_map();
				1:       drain_map();
				default: churn_map();
			endcase
			phase++;
		end
		wait_idle();
		calm = 1'b0;
		repeat (10) @(posedge clk);
		n_free = planned - n_alloc;
		$display("Ran %0d requests: %0d allocates, %0d frees, in both search modes",
			planned, n_alloc, n_free);
		$display("Saw %0d full-map replies and %0d frees of unused slots",
			n_full, n_warn);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#400000;
		$display("Timed out with %0d requests and %0d replies outstanding",
			req_q.size(), grant_q.size());
		$display("TB_ERROR");
		$finish;
	end

endmodule
